// ===== hw/rtl/ansi_sgr_text_attribute_parser_unit_assert.svh =====
// Assertion macros used by the back end of the ANSI SGR text attribute parser RTL.
`ifndef ANSI_SGR_TEXT_ATTRIBUTE_PARSER_UNIT_ASSERT_SVH
`define ANSI_SGR_TEXT_ATTRIBUTE_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checks that the consequent follows whenever the antecedent holds.
`define ASGR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("asgr assertion failed");
// Checks that the condition never holds outside of reset.
`define ASGR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("asgr assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define ASGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("asgr assertion failed");
`else
`define ASGR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASGR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define ASGR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/asgr_pkg.sv =====
// Package with types, constants and color tables of the ANSI SGR attribute parser.
package asgr_pkg;

    // Escape buffer and parameter limits.
    localparam int ESCAPE_BUFFER_BYTES = 32;
    localparam int MAX_PARAMETERS      = 16;
    localparam int ESC_LEN_W           = 6;
    localparam int PARAM_CNT_W         = 5;
    localparam logic [ESC_LEN_W-1:0]   ESC_LEN_LAST = ESC_LEN_W'(ESCAPE_BUFFER_BYTES - 1);
    localparam logic [PARAM_CNT_W-1:0] PARAM_LIMIT  = PARAM_CNT_W'(MAX_PARAMETERS);

    // Queue between the classifier and the executor.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_BRACKET = 8'h5B;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_TERM_M  = 8'h6D;
    localparam logic [7:0] CH_TERM_H  = 8'h48;
    localparam logic [7:0] CH_TERM_J  = 8'h4A;
    localparam logic [7:0] CH_TERM_K  = 8'h4B;

    // Colors and SGR codes.
    localparam logic [31:0] RESET_FOREGROUND = 32'hFFCCCCCC;
    localparam logic [31:0] CLEAR_BACKGROUND = 32'h00000000;
    localparam logic [7:0]  SGR_RESET        = 8'd0;
    localparam logic [7:0]  SGR_BOLD         = 8'd1;
    localparam logic [7:0]  SGR_FG_NORMAL    = 8'd30;
    localparam logic [7:0]  SGR_BG_NORMAL    = 8'd40;
    localparam logic [7:0]  SGR_FG_BRIGHT    = 8'd90;
    localparam logic [7:0]  SGR_BG_BRIGHT    = 8'd100;
    localparam logic [7:0]  SGR_RANGE_SPAN   = 8'd7;
    localparam logic [7:0]  ACC_MAX          = 8'hFF;

    // Output kinds.
    localparam logic OUT_KIND_TEXT  = 1'b0;
    localparam logic OUT_KIND_BREAK = 1'b1;

    // Input kinds.
    localparam logic IN_KIND_BYTE  = 1'b0;
    localparam logic IN_KIND_CLEAR = 1'b1;

    // Item class decided by the front end.
    typedef enum logic [1:0] {
        ITEM_CLEAR,
        ITEM_ESC,
        ITEM_BYTE
    } asgr_item_cls_t;

    // Classified item as held in the queue.
    typedef struct packed {
        asgr_item_cls_t cls;
        logic [7:0]     byte_val;
        logic           is_digit;
        logic           is_term;
        logic           is_bracket;
        logic           is_newline;
    } asgr_entry_t;

    // Text attribute set.
    typedef struct packed {
        logic [31:0] fg;
        logic [31:0] bg;
        logic        bold;
    } asgr_attr_t;

    // Standard eight-color table.
    function automatic logic [31:0] normal_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'hFF000000;
            3'd1:    c = 32'hFFCC0000;
            3'd2:    c = 32'hFF00CC00;
            3'd3:    c = 32'hFFCCCC00;
            3'd4:    c = 32'hFF0000CC;
            3'd5:    c = 32'hFFCC00CC;
            3'd6:    c = 32'hFF00CCCC;
            3'd7:    c = 32'hFFCCCCCC;
            default: c = 32'hFF000000;
        endcase
        return c;
    endfunction

    // Bright eight-color table.
    function automatic logic [31:0] bright_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'hFF666666;
            3'd1:    c = 32'hFFFF6666;
            3'd2:    c = 32'hFF66FF66;
            3'd3:    c = 32'hFFFFFF66;
            3'd4:    c = 32'hFF6666FF;
            3'd5:    c = 32'hFFFF66FF;
            3'd6:    c = 32'hFF66FFFF;
            3'd7:    c = 32'hFFFFFFFF;
            default: c = 32'hFF666666;
        endcase
        return c;
    endfunction

    // Applies one SGR code to an attribute set; unknown codes leave it unchanged.
    function automatic asgr_attr_t apply_code(input asgr_attr_t a, input logic [7:0] code,
                                              input logic [31:0] def_fg);
        asgr_attr_t r;
        logic [7:0] d;
        r = a;
        d = 8'd0;
        if (code == SGR_RESET) begin
            r.fg   = def_fg;
            r.bg   = CLEAR_BACKGROUND;
            r.bold = 1'b0;
        end else if (code == SGR_BOLD) begin
            r.bold = 1'b1;
        end else if (code >= SGR_FG_NORMAL && code <= SGR_FG_NORMAL + SGR_RANGE_SPAN) begin
            d    = code - SGR_FG_NORMAL;
            r.fg = normal_color(d[2:0]);
        end else if (code >= SGR_BG_NORMAL && code <= SGR_BG_NORMAL + SGR_RANGE_SPAN) begin
            d    = code - SGR_BG_NORMAL;
            r.bg = normal_color(d[2:0]);
        end else if (code >= SGR_FG_BRIGHT && code <= SGR_FG_BRIGHT + SGR_RANGE_SPAN) begin
            d    = code - SGR_FG_BRIGHT;
            r.fg = bright_color(d[2:0]);
        end else if (code >= SGR_BG_BRIGHT && code <= SGR_BG_BRIGHT + SGR_RANGE_SPAN) begin
            d    = code - SGR_BG_BRIGHT;
            r.bg = bright_color(d[2:0]);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/asgr_in_if.sv =====
// Input channel interface: stream byte or clear command with valid/ready.
interface asgr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_in;

    modport source (output valid, output kind, output byte_in, input ready);
    modport sink (input valid, input kind, input byte_in, output ready);
endinterface

// ===== hw/rtl/asgr_out_if.sv =====
// Output channel interface: attributed text byte or line break with valid/ready.
interface asgr_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  out_byte;
    logic [31:0] fg_argb;
    logic [31:0] bg_argb;
    logic        bold;

    modport source (output valid, output out_kind, output out_byte, output fg_argb,
                    output bg_argb, output bold, input ready);
    modport sink (input valid, input out_kind, input out_byte, input fg_argb,
                  input bg_argb, input bold, output ready);
endinterface

// ===== hw/rtl/asgr_front.sv =====
// Front end: accepts input transactions and classifies each byte for the queue.
module asgr_front (
    asgr_in_if.sink                in_ch,
    input  logic                   queue_full,
    output logic                   push_valid,
    output asgr_pkg::asgr_entry_t  push_entry
);

    // Accept whenever the queue has room.
    assign in_ch.ready = !queue_full;
    assign push_valid  = in_ch.valid && !queue_full;

    // Decode the byte into its class and character flags.
    always_comb
    begin
        push_entry.byte_val   = in_ch.byte_in;
        push_entry.is_digit   = (in_ch.byte_in >= asgr_pkg::CH_DIGIT_0) &&
                                (in_ch.byte_in <= asgr_pkg::CH_DIGIT_9);
        push_entry.is_term    = (in_ch.byte_in == asgr_pkg::CH_TERM_M) ||
                                (in_ch.byte_in == asgr_pkg::CH_TERM_H) ||
                                (in_ch.byte_in == asgr_pkg::CH_TERM_J) ||
                                (in_ch.byte_in == asgr_pkg::CH_TERM_K);
        push_entry.is_bracket = (in_ch.byte_in == asgr_pkg::CH_BRACKET);
        push_entry.is_newline = (in_ch.byte_in == asgr_pkg::CH_NEWLINE);
        if (in_ch.kind == asgr_pkg::IN_KIND_CLEAR)
        begin
            push_entry.cls = asgr_pkg::ITEM_CLEAR;
        end
        else if (in_ch.byte_in == asgr_pkg::CH_ESC)
        begin
            push_entry.cls = asgr_pkg::ITEM_ESC;
        end
        else
        begin
            push_entry.cls = asgr_pkg::ITEM_BYTE;
        end
    end

endmodule

// ===== hw/rtl/asgr_queue.sv =====
// Short FIFO that decouples the classifier from the executor.
module asgr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  asgr_pkg::asgr_entry_t  push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   pop_valid,
    output asgr_pkg::asgr_entry_t  pop_entry
);

    asgr_pkg::asgr_entry_t                  slots_reg [asgr_pkg::QUEUE_DEPTH];
    logic [asgr_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [asgr_pkg::QUEUE_PTR_W-1:0]       wr_ptr_next;
    logic [asgr_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [asgr_pkg::QUEUE_PTR_W-1:0]       rd_ptr_next;
    logic [asgr_pkg::QUEUE_CNT_W-1:0]       count_reg;
    logic [asgr_pkg::QUEUE_CNT_W-1:0]       count_next;
    logic                                   do_push;
    logic                                   do_pop;

    // Status and head of queue.
    assign full      = (count_reg == asgr_pkg::QUEUE_CNT_W'(asgr_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/asgr_back.sv =====
// Back end: escape sequence state, SGR attribute staging and the output register.
`include "ansi_sgr_text_attribute_parser_unit_assert.svh"

module asgr_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [31:0]            cfg_write_data,
    input  logic                   pop_valid,
    input  asgr_pkg::asgr_entry_t  pop_entry,
    output logic                   pop,
    asgr_out_if.source             out_ch
);

    // Configuration and escape state.
    logic [31:0]                          def_fg_reg;
    logic                                 escape_active_reg;
    logic                                 escape_active_next;
    logic [asgr_pkg::ESC_LEN_W-1:0]       esc_len_reg;
    logic [asgr_pkg::ESC_LEN_W-1:0]       esc_len_next;
    logic                                 bracket_reg;
    logic                                 bracket_next;
    logic [7:0]                           acc_reg;
    logic [7:0]                           acc_next;
    logic                                 num_busy_reg;
    logic                                 num_busy_next;
    logic [asgr_pkg::PARAM_CNT_W-1:0]     taken_reg;
    logic [asgr_pkg::PARAM_CNT_W-1:0]     taken_next;
    asgr_pkg::asgr_attr_t                 stg_attr_reg;
    asgr_pkg::asgr_attr_t                 stg_attr_next;
    asgr_pkg::asgr_attr_t                 cur_attr_reg;
    asgr_pkg::asgr_attr_t                 cur_attr_next;

    // Output register.
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 out_kind_reg;
    logic [7:0]                           out_byte_reg;
    asgr_pkg::asgr_attr_t                 out_attr_reg;

    logic                                 out_free;
    logic                                 emit;
    logic                                 do_step;
    logic                                 go_idle;
    logic                                 bracket_eff;
    logic [11:0]                          acc_sum;

    // A text byte needs a free output slot; everything else proceeds at once.
    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = pop_valid && (pop_entry.cls == asgr_pkg::ITEM_BYTE) && !escape_active_reg;
    assign do_step  = pop_valid && (!emit || out_free);
    assign pop      = do_step;

    // Escape sequence and attribute update for the item at the head of the queue.
    always_comb
    begin
        escape_active_next = escape_active_reg;
        esc_len_next       = esc_len_reg;
        bracket_next       = bracket_reg;
        acc_next           = acc_reg;
        num_busy_next      = num_busy_reg;
        taken_next         = taken_reg;
        stg_attr_next      = stg_attr_reg;
        cur_attr_next      = cur_attr_reg;
        go_idle            = 1'b0;
        bracket_eff        = bracket_reg;
        acc_sum            = {4'd0, acc_reg} * 12'd10 + {8'd0, pop_entry.byte_val[3:0]};
        if (do_step)
        begin
            case (pop_entry.cls)
                asgr_pkg::ITEM_CLEAR:
                begin
                    cur_attr_next.fg   = def_fg_reg;
                    cur_attr_next.bg   = asgr_pkg::CLEAR_BACKGROUND;
                    cur_attr_next.bold = 1'b0;
                    stg_attr_next      = cur_attr_next;
                    go_idle            = 1'b1;
                end
                asgr_pkg::ITEM_ESC:
                begin
                    go_idle       = 1'b1;
                    stg_attr_next = cur_attr_reg;
                end
                asgr_pkg::ITEM_BYTE:
                begin
                    if (escape_active_reg)
                    begin
                        if (esc_len_reg >= asgr_pkg::ESC_LEN_LAST)
                        begin
                            // Buffer full: the whole sequence is dropped.
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            esc_len_next = esc_len_reg + 1'b1;
                            if (esc_len_reg == '0)
                            begin
                                bracket_eff  = pop_entry.is_bracket;
                                bracket_next = pop_entry.is_bracket;
                            end
                            else if (bracket_reg)
                            begin
                                if (pop_entry.is_digit)
                                begin
                                    // Digits accumulate with saturation at 255.
                                    if (!num_busy_reg)
                                    begin
                                        acc_next = {4'd0, pop_entry.byte_val[3:0]};
                                    end
                                    else if (acc_sum > {4'd0, asgr_pkg::ACC_MAX})
                                    begin
                                        acc_next = asgr_pkg::ACC_MAX;
                                    end
                                    else
                                    begin
                                        acc_next = acc_sum[7:0];
                                    end
                                    num_busy_next = 1'b1;
                                end
                                else if (num_busy_reg)
                                begin
                                    // Any non-digit closes the number in progress.
                                    if (taken_reg < asgr_pkg::PARAM_LIMIT)
                                    begin
                                        stg_attr_next = asgr_pkg::apply_code(stg_attr_reg,
                                                                             acc_reg, def_fg_reg);
                                        taken_next    = taken_reg + 1'b1;
                                    end
                                    num_busy_next = 1'b0;
                                    acc_next      = 8'd0;
                                end
                            end
                            if (pop_entry.is_term)
                            begin
                                if (bracket_eff)
                                begin
                                    cur_attr_next = stg_attr_next;
                                end
                                go_idle = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    go_idle = 1'b0;
                end
            endcase
            if (go_idle)
            begin
                escape_active_next = (pop_entry.cls == asgr_pkg::ITEM_ESC);
                esc_len_next       = '0;
                bracket_next       = 1'b0;
                acc_next           = 8'd0;
                num_busy_next      = 1'b0;
                taken_next         = '0;
            end
        end
    end

    // Output valid: held until taken, loaded by a text byte.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (do_step && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and attribute state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_fg_reg        <= asgr_pkg::RESET_FOREGROUND;
            escape_active_reg <= 1'b0;
            esc_len_reg       <= '0;
            bracket_reg       <= 1'b0;
            acc_reg           <= 8'd0;
            num_busy_reg      <= 1'b0;
            taken_reg         <= '0;
            stg_attr_reg      <= '{fg: asgr_pkg::RESET_FOREGROUND,
                                   bg: asgr_pkg::CLEAR_BACKGROUND, bold: 1'b0};
            cur_attr_reg      <= '{fg: asgr_pkg::RESET_FOREGROUND,
                                   bg: asgr_pkg::CLEAR_BACKGROUND, bold: 1'b0};
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                def_fg_reg <= cfg_write_data;
            end
            escape_active_reg <= escape_active_next;
            esc_len_reg       <= esc_len_next;
            bracket_reg       <= bracket_next;
            acc_reg           <= acc_next;
            num_busy_reg      <= num_busy_next;
            taken_reg         <= taken_next;
            stg_attr_reg      <= stg_attr_next;
            cur_attr_reg      <= cur_attr_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Output payload, loaded with the attributes in effect for the byte.
    always_ff @(posedge clk)
    begin
        if (do_step && emit)
        begin
            out_kind_reg <= pop_entry.is_newline ? asgr_pkg::OUT_KIND_BREAK
                                                 : asgr_pkg::OUT_KIND_TEXT;
            out_byte_reg <= pop_entry.byte_val;
            out_attr_reg <= cur_attr_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_kind = out_kind_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.fg_argb  = out_attr_reg.fg;
    assign out_ch.bg_argb  = out_attr_reg.bg;
    assign out_ch.bold     = out_attr_reg.bold;

    // The escape length never passes the last buffer position.
    `ASGR_ASSERT_NEVER(a_len_bound, clk, rst_n, esc_len_reg > asgr_pkg::ESC_LEN_LAST)
    // No more parameters are applied than the limit allows.
    `ASGR_ASSERT_NEVER(a_taken_bound, clk, rst_n, taken_reg > asgr_pkg::PARAM_LIMIT)
    // Outside an escape the sequence state is fully idle.
    `ASGR_ASSERT_IMPLY(a_idle_clean, clk, rst_n, !escape_active_reg,
                       esc_len_reg == '0 && !bracket_reg && !num_busy_reg && taken_reg == '0)
    // An emitted text byte is presented on the output in the next cycle.
    `ASGR_ASSERT_NEXT(a_emit_shows, clk, rst_n, do_step && emit, out_valid_reg)

endmodule

// ===== hw/rtl/ansi_sgr_text_attribute_parser_unit.sv =====
// Top level of the ANSI SGR text attribute parser: classifier, queue and executor.
// A text byte passes through a queue slot and then the output register before it is presented.
// One input transaction is taken per cycle while the queue has room; a held output slot stalls the executor.
// A four-entry queue parts the input from the executor; the output is a register slot.
// Reset (rst_n low, asynchronous) idles the escape state and restores default attributes.
module ansi_sgr_text_attribute_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    asgr_in_if.sink     in_ch,
    asgr_out_if.source  out_ch
);

    logic                  push_valid;
    asgr_pkg::asgr_entry_t push_entry;
    logic                  queue_full;
    logic                  pop;
    logic                  pop_valid;
    asgr_pkg::asgr_entry_t pop_entry;

    // Input classification.
    asgr_front u_front (
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // Decoupling queue.
    asgr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    // Escape handling, attributes and output.
    asgr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pop_valid      (pop_valid),
        .pop_entry      (pop_entry),
        .pop            (pop),
        .out_ch         (out_ch)
    );

endmodule
